FILE: rtl/ifmt_pkg.sv
// ifmt_pkg: shared constants and the digit character table for the integer field formatter
// no dependencies; imported by integer_field_formatter and ifmt_checker
`timescale 1ns / 1ps

package ifmt_pkg;

  // defaults for the top level parameters
  localparam int MAX_FIELD_DEF  = 63;
  localparam int VALUE_BITS_DEF = 32;

  // fixed field widths
  localparam int IN_VALUE_W = 32;
  localparam int FIELD_W    = 6;
  localparam int LEN_W      = FIELD_W + 1;
  localparam int CHAR_W     = 8;

  // conversion modes
  localparam logic FUNC_DEC = 1'b0;
  localparam logic FUNC_HEX = 1'b1;

  // output characters
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;

  // one digit 0..15 to its lower-case ascii character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_LC_A + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

FILE: rtl/integer_field_formatter.sv
// integer_field_formatter: printf style %d / %x formatting with width and precision
// depends on ifmt_pkg; checked by ifmt_checker (bound in its own file)
`timescale 1ns / 1ps

// Takes one integer per transaction (start high while busy is low) and sends the
// formatted text back one character per cycle on out_char_out, each character shown
// for exactly one cycle with out_valid high; the receiver cannot stall, so it must
// take every character as it comes. out_last marks the final character. A zero value
// with an explicit precision of zero and a width of zero gives no characters at all.
// An item goes through bit-serial conversion (shift-and-add-3 for decimal, plain
// shifting for hex), then strips leading zero digits (up to VALUE_BITS/3) and finds
// the leading digit, then passes a setup state, and then sends its characters (up
// to MAX_FIELD + 1). Busy is high for the whole item and drops in the cycle that
// shows the last character, so the next transaction can be accepted at the edge
// that ends that cycle.
module integer_field_formatter
  import ifmt_pkg::*;
#(
  parameter int MAX_FIELD  = MAX_FIELD_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input transactions
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_func,
  input  logic [IN_VALUE_W-1:0] in_value,
  input  logic [FIELD_W-1:0]    in_width,
  input  logic [FIELD_W-1:0]    in_precision,
  input  logic                  in_precision_given,
  // result transactions, one character each
  output logic                  out_valid,
  output logic [CHAR_W-1:0]     out_char_out,
  output logic                  out_last
);

  // digit register sized for both bases: decimal needs under VALUE_BITS/3 + 1 digits
  localparam int DIG_N = VALUE_BITS / 3 + 1;
  localparam int BCD_W = DIG_N * 4;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int ND_W  = $clog2(DIG_N + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_SETUP,
    ST_EMIT
  } state_t;

  state_t               state_r;
  logic [VALUE_BITS-1:0] mag_r;      // magnitude, shifted out msb first
  logic [BCD_W-1:0]     bcd_r;       // digits, most significant at the top
  logic [CNT_W-1:0]     bit_cnt_r;
  logic [ND_W-1:0]      nd_r;        // digits remaining to send
  logic                 func_r;
  logic                 neg_r;
  logic                 suppress_r;  // zero value with explicit zero precision
  logic [FIELD_W-1:0]   width_r;
  logic [FIELD_W-1:0]   prec_r;
  logic [FIELD_W-1:0]   sp_r;        // spaces remaining
  logic [FIELD_W-1:0]   zp_r;        // padding zeros remaining
  logic [LEN_W-1:0]     rem_r;       // characters remaining in this item
  logic                 out_valid_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic                 out_last_r;

  // ---------------------------------------------------------------
  // load path: trim the value, clamp the fields, take the magnitude
  // ---------------------------------------------------------------
  logic [VALUE_BITS+IN_VALUE_W-1:0] value_ext;
  logic [VALUE_BITS-1:0]            value_in;
  logic                             neg_in;
  logic [VALUE_BITS-1:0]            mag_in;
  logic [FIELD_W-1:0]               width_cl;
  logic [FIELD_W-1:0]               prec_cl;
  logic                             accept;

  assign accept    = start && !busy;
  assign value_ext = {{VALUE_BITS{1'b0}}, in_value};
  assign value_in  = value_ext[VALUE_BITS-1:0];
  assign neg_in    = (in_func == FUNC_DEC) && value_in[VALUE_BITS-1];
  assign mag_in    = neg_in ? (~value_in + VALUE_BITS'(1)) : value_in;
  assign width_cl  = (in_width > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD) : in_width;
  assign prec_cl   = (in_precision > FIELD_W'(MAX_FIELD)) ? FIELD_W'(MAX_FIELD)
                                                            : in_precision;

  // ---------------------------------------------------------------
  // conversion step: add 3 to every digit of 5 or more (decimal only),
  // then shift the next magnitude bit in at the bottom
  // ---------------------------------------------------------------
  logic [BCD_W-1:0] bcd_adj;
  logic [BCD_W-1:0] bcd_nxt;

  always_comb begin
    for (int i = 0; i < DIG_N; i++) begin
      if ((func_r == FUNC_DEC) && (bcd_r[i*4 +: 4] >= 4'd5)) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
    bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[VALUE_BITS-1]};
  end

  logic [3:0] top_digit;
  assign top_digit = bcd_r[BCD_W-1 -: 4];

  // ---------------------------------------------------------------
  // field layout, worked out once the digit count is known
  // ---------------------------------------------------------------
  logic [ND_W-1:0]  nd_eff;
  logic [LEN_W-1:0] body;
  logic [LEN_W-1:0] used;
  logic [LEN_W-1:0] spaces;
  logic [LEN_W-1:0] zeros;
  logic [LEN_W-1:0] total;

  always_comb begin
    nd_eff = suppress_r ? '0 : nd_r;
    body   = (LEN_W'(nd_eff) > LEN_W'(prec_r)) ? LEN_W'(nd_eff) : LEN_W'(prec_r);
    zeros  = (LEN_W'(prec_r) > LEN_W'(nd_eff)) ? (LEN_W'(prec_r) - LEN_W'(nd_eff))
                                               : '0;
    used   = body + LEN_W'(neg_r);
    spaces = (LEN_W'(width_r) > used) ? (LEN_W'(width_r) - used) : '0;
    total  = (LEN_W'(width_r) > used) ? LEN_W'(width_r) : used;
  end

  // ---------------------------------------------------------------
  // sequencer with registered outputs
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      // one character leaves for every cycle spent in emit
      out_valid_r <= (state_r == ST_EMIT);
      out_last_r  <= (state_r == ST_EMIT) && (rem_r == LEN_W'(1));
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            func_r     <= in_func;
            neg_r      <= neg_in;
            mag_r      <= mag_in;
            bcd_r      <= '0;
            bit_cnt_r  <= CNT_W'(VALUE_BITS);
            width_r    <= width_cl;
            prec_r     <= prec_cl;
            suppress_r <= (value_in == '0) && in_precision_given && (prec_cl == '0);
            state_r    <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd_r     <= bcd_nxt;
          mag_r     <= {mag_r[VALUE_BITS-2:0], 1'b0};
          bit_cnt_r <= bit_cnt_r - CNT_W'(1);
          if (bit_cnt_r == CNT_W'(1)) begin
            nd_r    <= ND_W'(DIG_N);
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // drop leading zero digits, keeping at least one
          if ((nd_r > ND_W'(1)) && (top_digit == 4'd0)) begin
            bcd_r <= {bcd_r[BCD_W-5:0], 4'd0};
            nd_r  <= nd_r - ND_W'(1);
          end else begin
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          nd_r  <= nd_eff;
          sp_r  <= spaces[FIELD_W-1:0];
          zp_r  <= zeros[FIELD_W-1:0];
          rem_r <= total;
          if (total == '0) begin
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          rem_r <= rem_r - LEN_W'(1);
          priority if (sp_r != '0) begin
            out_char_r <= CH_SPACE;
            sp_r       <= sp_r - FIELD_W'(1);
          end else if (neg_r) begin
            out_char_r <= CH_MINUS;
            neg_r      <= 1'b0;
          end else if (zp_r != '0) begin
            out_char_r <= CH_ZERO;
            zp_r       <= zp_r - FIELD_W'(1);
          end else begin
            out_char_r <= digit_char(top_digit);
            bcd_r      <= {bcd_r[BCD_W-5:0], 4'd0};
            nd_r       <= nd_r - ND_W'(1);
          end
          if (rem_r == LEN_W'(1)) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;

endmodule

FILE: rtl/ifmt_checker.sv
// ifmt_checker: port-level assertions for integer_field_formatter, and the bind that attaches it
// depends on ifmt_pkg; binds to integer_field_formatter
`timescale 1ns / 1ps

module ifmt_checker
  import ifmt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [CHAR_W-1:0] out_char_out,
  input logic              out_last
);

  // a last marker only rides on a character transaction
  a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last |-> out_valid)
    else $error("out_last without out_valid");

  // while characters remain the block stays busy
  a_busy_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> busy)
    else $error("idle with characters still owed");

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // nothing follows the last character of an item
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("character right after the last one");

  // only spaces, minus, and lower-case digits are sent
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_char_out == CH_SPACE) || (out_char_out == CH_MINUS) ||
                   ((out_char_out >= CH_ZERO) && (out_char_out <= CH_NINE)) ||
                   ((out_char_out >= CH_LC_A) && (out_char_out <= CH_LC_F))))
    else $error("unexpected output character");

endmodule

bind integer_field_formatter ifmt_checker u_ifmt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_char_out (out_char_out),
  .out_last     (out_last)
);
